// ===== sv/cpct_pkg.sv =====
// Shared types for the collider pair contact test.
`timescale 1ns / 1ps

package cpct_pkg;

	localparam int MagW = 32;

	// Classified pair as it travels from the front to the back
	typedef struct packed {
		logic                 is_box;
		logic                 box_hit;
		logic [1:0]           box_ax;
		logic                 box_neg;
		logic [31:0]          box_pen;
		logic                 negate;
		logic [2:0]           sgn;
		logic [2:0][MagW-1:0] mag;
		logic [31:0]          rad;
	} job_t;

	localparam logic [1:0] AxX = 2'd0;
	localparam logic [1:0] AxY = 2'd1;
	localparam logic [1:0] AxZ = 2'd2;

	localparam logic [1:0] KindBoxBox    = 2'd0;
	localparam logic [1:0] KindSphBox    = 2'd1;
	localparam logic [1:0] KindBoxSph    = 2'd2;
	localparam logic [1:0] KindSphSph    = 2'd3;

endpackage

// ===== sv/cpct_front.sv =====
// Front: classifies a pair, does the box-box test and forms the sphere residual.
`timescale 1ns / 1ps

module cpct_front import cpct_pkg::*; (
	input  logic [1:0]         pair_kind,
	input  logic signed [31:0] offset_x,
	input  logic signed [31:0] offset_y,
	input  logic signed [31:0] offset_z,
	input  logic [30:0]        a_ext_x,
	input  logic [30:0]        a_ext_y,
	input  logic [30:0]        a_ext_z,
	input  logic [30:0]        b_ext_x,
	input  logic [30:0]        b_ext_y,
	input  logic [30:0]        b_ext_z,
	output job_t               job
);

	logic signed [31:0] off [3];
	logic [30:0]        ea [3];
	logic [30:0]        eb [3];
	logic [31:0]        omag [3];
	logic signed [33:0] bd [3];
	logic signed [32:0] c [3];
	logic signed [32:0] bx [3];
	logic signed [33:0] dd [3];
	logic               a_sph;

	assign off[0] = offset_x;
	assign off[1] = offset_y;
	assign off[2] = offset_z;
	assign ea[0] = a_ext_x;
	assign ea[1] = a_ext_y;
	assign ea[2] = a_ext_z;
	assign eb[0] = b_ext_x;
	assign eb[1] = b_ext_y;
	assign eb[2] = b_ext_z;
	assign a_sph = (pair_kind == KindSphBox);

	always_comb begin
		job = '0;
		job.is_box = (pair_kind == KindBoxBox);
		job.negate = (pair_kind == KindBoxSph);
		for (int i = 0; i < 3; i++) begin
			omag[i] = off[i][31] ? 32'(-34'(off[i])) : 32'(off[i]);
			bd[i] = 34'(ea[i]) + 34'(eb[i]) - 34'(omag[i]);
			c[i] = a_sph ? 33'(off[i]) : -33'(off[i]);
			bx[i] = a_sph ? 33'(eb[i]) : 33'(ea[i]);
			// residual from the box surface, zero inside the box
			if (c[i] > bx[i])
				dd[i] = 34'(c[i]) - 34'(bx[i]);
			else if (c[i] < -bx[i])
				dd[i] = 34'(c[i]) + 34'(bx[i]);
			else
				dd[i] = '0;
		end
		job.box_hit = (bd[0] > 0) && (bd[1] > 0) && (bd[2] > 0);
		if (bd[0] < bd[1] && bd[0] < bd[2])
			job.box_ax = AxX;
		else if (bd[1] < bd[2])
			job.box_ax = AxY;
		else
			job.box_ax = AxZ;
		case (job.box_ax)
			AxX: begin
				job.box_pen = bd[0][31:0];
				job.box_neg = off[0][31];
			end
			AxY: begin
				job.box_pen = bd[1][31:0];
				job.box_neg = off[1][31];
			end
			default: begin
				job.box_pen = bd[2][31:0];
				job.box_neg = off[2][31];
			end
		endcase
		if (pair_kind == KindSphSph) begin
			for (int i = 0; i < 3; i++) begin
				job.mag[i] = omag[i];
				job.sgn[i] = off[i][31];
			end
			job.rad = 32'(ea[0]) + 32'(eb[0]);
		end else begin
			for (int i = 0; i < 3; i++) begin
				job.mag[i] = dd[i][33] ? 32'(-dd[i]) : 32'(dd[i]);
				job.sgn[i] = dd[i][33];
			end
			job.rad = a_sph ? 32'(ea[0]) : 32'(eb[0]);
		end
	end

endmodule

// ===== sv/cpct_fifo.sv =====
// Short queue between the front and the back.
`timescale 1ns / 1ps

module cpct_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	logic [W-1:0]    mem_q [DEPTH];
	logic [PtrW-1:0] wp_q;
	logic [PtrW-1:0] rp_q;
	logic [CntW-1:0] cnt_q;

	assign full  = (cnt_q == CntW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= (wp_q == PtrW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (rd)
				rp_q <= (rp_q == PtrW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + CntW'(wr) - CntW'(rd);
		end
	end

	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(DEPTH)) else $error("queue count beyond depth");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> !empty) else $error("queue read while empty");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr && full |-> rd) else $error("queue written while full");

endmodule

// ===== sv/cpct_back.sv =====
// Back: squared distance, pipelined square root and normal division, result register.
`timescale 1ns / 1ps

module cpct_back import cpct_pkg::*; #(
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	input  job_t               job,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               collided,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic [31:0]        penetration
);

	localparam int NF   = NORMAL_FRAC_BITS;
	localparam int QW   = NF + 1;
	localparam int NSQ  = 32;
	localparam int PREP = 2 + NSQ;
	localparam int OUTS = PREP + 1 + QW;
	localparam int NST  = OUTS + 1;
	localparam int NumW = MagW + QW;

	logic            en;
	logic [NST-1:0]  vld_q;
	job_t            job_s [OUTS];
	logic [63:0]     sq_s1 [3];
	logic [63:0]     r2_s1;
	logic [63:0]     d2_s2;
	logic [63:0]     r2_s2;
	logic [63:0]     rt_x_s [NSQ];
	logic [63:0]     rt_r_s [NSQ];
	logic            hit_s [NSQ + 1 + QW];
	logic [31:0]     dist_s [QW + 1];
	logic [31:0]     rem_s [QW + 1][3];
	logic [QW-1:0]   low_s [QW + 1][3];
	logic [QW-1:0]   quo_s [QW + 1][3];

	assign en  = !(vld_q[NST-1] && out_stall);
	assign pop = en && job_valid;
	assign out_valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[NST-2:0], job_valid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			job_s[0] <= job;
			for (int i = 1; i < OUTS; i++)
				job_s[i] <= job_s[i-1];
			for (int i = 0; i < 3; i++)
				sq_s1[i] <= 64'(job.mag[i]) * 64'(job.mag[i]);
			r2_s1 <= 64'(job.rad) * 64'(job.rad);
			d2_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			r2_s2 <= r2_s1;
		end
	end

	// digit-by-digit square root, one result bit per stage
	for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
		logic [63:0] x_in;
		logic [63:0] r_in;
		logic [63:0] bitv;
		logic [63:0] trial;
		logic        hit_in;
		if (k == 0) begin : g_first
			assign x_in   = d2_s2;
			assign r_in   = '0;
			assign hit_in = d2_s2 < r2_s2;
		end else begin : g_next
			assign x_in   = rt_x_s[k-1];
			assign r_in   = rt_r_s[k-1];
			assign hit_in = hit_s[k-1];
		end
		assign bitv  = 64'(1) << (62 - 2 * k);
		assign trial = r_in + bitv;
		always_ff @(posedge clk) begin
			if (en) begin
				if (x_in >= trial) begin
					rt_x_s[k] <= x_in - trial;
					rt_r_s[k] <= (r_in >> 1) + bitv;
				end else begin
					rt_x_s[k] <= x_in;
					rt_r_s[k] <= r_in >> 1;
				end
				hit_s[k] <= hit_in;
			end
		end
	end

	// rounded numerator, then restoring division with the remainder kept below dist
	always_ff @(posedge clk) begin
		logic [31:0]   dlen;
		logic [NumW-1:0] num;
		if (en) begin
			dlen = rt_r_s[NSQ-1][31:0];
			dist_s[0] <= dlen;
			hit_s[NSQ] <= hit_s[NSQ-1];
			for (int i = 0; i < 3; i++) begin
				num = (NumW'(job_s[PREP-1].mag[i]) << NF) + NumW'(dlen >> 1);
				rem_s[0][i] <= num[NumW-1:QW];
				low_s[0][i] <= num[QW-1:0];
				quo_s[0][i] <= '0;
			end
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		always_ff @(posedge clk) begin
			logic [32:0] t;
			logic        ge;
			if (en) begin
				dist_s[j+1] <= dist_s[j];
				hit_s[NSQ+1+j] <= hit_s[NSQ+j];
				for (int i = 0; i < 3; i++) begin
					t  = {rem_s[j][i], low_s[j][i][QW-1-j]};
					ge = t >= {1'b0, dist_s[j]};
					rem_s[j+1][i] <= ge ? 32'(t - {1'b0, dist_s[j]}) : t[31:0];
					low_s[j+1][i] <= low_s[j][i];
					quo_s[j+1][i] <= {quo_s[j][i][QW-2:0], ge};
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		job_t        jf;
		logic [31:0] unit;
		logic [31:0] nv [3];
		logic [31:0] pen;
		logic        hit;
		if (en) begin
			jf   = job_s[OUTS-1];
			unit = 32'(1) << NF;
			nv[0] = '0;
			nv[1] = '0;
			nv[2] = '0;
			pen  = '0;
			hit  = 1'b0;
			if (jf.is_box) begin
				hit = jf.box_hit;
				if (hit) begin
					nv[jf.box_ax] = jf.box_neg ? -unit : unit;
					pen = jf.box_pen;
				end
			end else begin
				hit = hit_s[NSQ+QW];
				if (hit) begin
					pen = jf.rad - dist_s[QW];
					if (dist_s[QW] == '0) begin
						nv[0] = unit;
					end else begin
						for (int i = 0; i < 3; i++)
							nv[i] = (jf.sgn[i] ^ jf.negate) ? -32'(quo_s[QW][i])
								: 32'(quo_s[QW][i]);
					end
				end
			end
			collided    <= hit;
			normal_x    <= nv[0][15:0];
			normal_y    <= nv[1][15:0];
			normal_z    <= nv[2][15:0];
			penetration <= pen;
		end
	end

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !collided |-> normal_x == '0 && normal_y == '0 && normal_z == '0
			&& penetration == '0) else $error("miss with nonzero contact");
	a_hit_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && collided |-> penetration != '0) else $error("hit with zero depth");
	a_pop_flow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> vld_q[0]) else $error("popped item lost at back entry");

endmodule

// ===== sv/collider_pair_contact_test.sv =====
// Top level of the collider pair contact test.
`timescale 1ns / 1ps
// Narrow-phase contact test for one collider pair per item.
// Input channel: in_valid/in_stall with pair_kind, offset_x/y/z (A minus B,
// Q16.16) and half sizes or sphere radius (ext_x) for each body.
// Output channel: out_valid/out_stall with collided, normal_x/y/z (toward A,
// NORMAL_FRAC_BITS fraction bits, low 16 bits) and penetration (Q16.16).
// Throughput: one pair per cycle when nothing stalls. Path from acceptance
// to out_valid: the 4-entry queue passes an item straight on, then a
// multiply stage, a sum stage, 32 square-root stages, a rounding stage,
// NORMAL_FRAC_BITS + 1 division stages and the result register.
// Box-box pairs travel the same pipeline so results stay in order.
// While a result waits under out_stall the whole back pipeline holds; the
// queue keeps taking pairs until its four entries are full, then in_stall rises.
// in_stall depends only on queue fill, never on in_valid.
// Reset empties the queue and clears all pipeline valid bits; no
// configuration is needed afterwards.
module collider_pair_contact_test import cpct_pkg::*; #(
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         pair_kind,
	input  logic signed [31:0] offset_x,
	input  logic signed [31:0] offset_y,
	input  logic signed [31:0] offset_z,
	input  logic [30:0]        a_ext_x,
	input  logic [30:0]        a_ext_y,
	input  logic [30:0]        a_ext_z,
	input  logic [30:0]        b_ext_x,
	input  logic [30:0]        b_ext_y,
	input  logic [30:0]        b_ext_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               collided,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic [31:0]        penetration
);

	job_t job_in;
	job_t job_out;
	logic q_full;
	logic q_empty;
	logic pop;
	logic push;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	cpct_front u_front (
		.pair_kind (pair_kind),
		.offset_x  (offset_x),
		.offset_y  (offset_y),
		.offset_z  (offset_z),
		.a_ext_x   (a_ext_x),
		.a_ext_y   (a_ext_y),
		.a_ext_z   (a_ext_z),
		.b_ext_x   (b_ext_x),
		.b_ext_y   (b_ext_y),
		.b_ext_z   (b_ext_z),
		.job       (job_in)
	);

	cpct_fifo #(
		.W     ($bits(job_t)),
		.DEPTH (4)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push),
		.wdata  (job_in),
		.rd     (pop),
		.rdata  (job_out),
		.full   (q_full),
		.empty  (q_empty)
	);

	cpct_back #(
		.NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (!q_empty),
		.job         (job_out),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.collided    (collided),
		.normal_x    (normal_x),
		.normal_y    (normal_y),
		.normal_z    (normal_z),
		.penetration (penetration)
	);

endmodule

// ===== test/collider_pair_contact_test_tb.sv =====
// Self-checking testbench for the collider pair contact test.
`timescale 1ns / 1ps

module collider_pair_contact_test_tb import cpct_pkg::*;;

	localparam int NFB = 14;
	localparam int LIMIT = 400000;

	typedef struct {
		logic [1:0]         kind;
		logic signed [31:0] ox, oy, oz;
		logic [30:0]        ax, ay, az, bx, by, bz;
	} pair_t;

	typedef struct {
		logic               hit;
		logic signed [15:0] nx, ny, nz;
		logic [31:0]        pen;
	} contact_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [1:0] pair_kind;
	logic signed [31:0] offset_x, offset_y, offset_z;
	logic [30:0] a_ext_x, a_ext_y, a_ext_z, b_ext_x, b_ext_y, b_ext_z;
	logic collided;
	logic signed [15:0] normal_x, normal_y, normal_z;
	logic [31:0] penetration;

	contact_t expected_contacts[$];
	int mismatches = 0;
	int cycles = 0;
	int send_idle_pct = 0, recv_idle_pct = 0;
	bit send_done = 0;

	collider_pair_contact_test #(.NORMAL_FRAC_BITS(NFB)) DUT (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned abs64(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	// residual vector against a limit; normal is offset over distance, rounded
	function automatic contact_t sphere_contact(longint d[3], longint unsigned r, bit neg);
		contact_t c;
		longint unsigned d2, dlen, q;
		longint n;
		c = '{0, 0, 0, 0, 0};
		d2 = 0;
		for (int i = 0; i < 3; i++) d2 += abs64(d[i]) * abs64(d[i]);
		if (!(d2 < r * r)) return c;
		dlen = int_sqrt(d2);
		c.hit = 1;
		c.pen = 32'(r - dlen);
		if (dlen == 0) begin
			c.nx = 16'(1 << NFB);
			return c;
		end
		for (int i = 0; i < 3; i++) begin
			q = ((abs64(d[i]) << NFB) + (dlen >> 1)) / dlen;
			n = d[i] < 0 ? -longint'(q) : longint'(q);
			if (neg) n = -n;
			if (i == 0) c.nx = 16'(n);
			else if (i == 1) c.ny = 16'(n);
			else c.nz = 16'(n);
		end
		return c;
	endfunction

	function automatic contact_t predict_contact(pair_t p);
		contact_t c;
		longint o[3], ea[3], eb[3], d[3], cv, cl;
		bit a_sph;
		int ax;
		c = '{0, 0, 0, 0, 0};
		o = '{p.ox, p.oy, p.oz};
		ea = '{p.ax, p.ay, p.az};
		eb = '{p.bx, p.by, p.bz};
		if (p.kind == KindBoxBox) begin
			c.hit = 1;
			for (int i = 0; i < 3; i++) begin
				d[i] = ea[i] + eb[i] - longint'(abs64(o[i]));
				if (d[i] <= 0) c.hit = 0;
			end
			if (c.hit) begin
				if (d[0] < d[1] && d[0] < d[2]) ax = 0;
				else if (d[1] < d[2]) ax = 1;
				else ax = 2;
				if (ax == 0) c.nx = o[0] < 0 ? -16'(1 << NFB) : 16'(1 << NFB);
				else if (ax == 1) c.ny = o[1] < 0 ? -16'(1 << NFB) : 16'(1 << NFB);
				else c.nz = o[2] < 0 ? -16'(1 << NFB) : 16'(1 << NFB);
				c.pen = 32'(d[ax]);
			end
		end else if (p.kind == KindSphSph) begin
			c = sphere_contact(o, ea[0] + eb[0], 0);
		end else begin
			a_sph = (p.kind == KindSphBox);
			for (int i = 0; i < 3; i++) begin
				cv = a_sph ? o[i] : -o[i];
				cl = cv;
				if (a_sph) begin
					if (cl > eb[i]) cl = eb[i];
					if (cl < -eb[i]) cl = -eb[i];
				end else begin
					if (cl > ea[i]) cl = ea[i];
					if (cl < -ea[i]) cl = -ea[i];
				end
				d[i] = cv - cl;
			end
			c = sphere_contact(d, a_sph ? ea[0] : eb[0], !a_sph);
		end
		return c;
	endfunction

	// Directed pairs; known contacts written in where obvious
	typedef struct {
		pair_t    p;
		bit       known;
		contact_t c;
	} row_t;
	localparam logic [30:0] EMAX = 31'h7FFF_FFFF;
	localparam logic [30:0] ONE = 31'h1_0000;
	row_t rows[] = '{
		'{'{KindBoxBox, 0, 0, 0, ONE, ONE, ONE, ONE, ONE, ONE}, 1,
			'{1, 0, 0, 16'sd16384, 32'h2_0000}},
		'{'{KindBoxBox, 32'sh2_0000, 0, 0, ONE, ONE, ONE, ONE, ONE, ONE}, 1,
			'{0, 0, 0, 0, 0}},
		'{'{KindBoxBox, -32'sh1_8000, 0, 0, ONE, ONE, ONE, ONE, ONE, ONE}, 1,
			'{1, -16'sd16384, 0, 0, 32'h8000}},
		'{'{KindBoxBox, 0, 32'sh1_0000, 0, ONE, ONE, ONE, ONE, ONE, ONE}, 1,
			'{1, 0, 16'sd16384, 0, 32'h1_0000}},
		'{'{KindBoxBox, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000, ONE, ONE, ONE, ONE, ONE, ONE}, 1,
			'{1, 0, 0, 16'sd16384, 32'h1_0000}},
		'{'{KindBoxBox, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			EMAX, EMAX, EMAX, EMAX, EMAX, EMAX}, 0, '{0, 0, 0, 0, 0}},
		'{'{KindBoxBox, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, 0}},
		'{'{KindSphSph, 0, 0, 0, ONE, 0, 0, ONE, 0, 0}, 1,
			'{1, 16'sd16384, 0, 0, 32'h2_0000}},
		'{'{KindSphSph, 32'sh2_0000, 0, 0, ONE, 0, 0, ONE, 0, 0}, 1,
			'{0, 0, 0, 0, 0}},
		'{'{KindSphSph, 0, -32'sh1_0000, 0, ONE, 0, 0, ONE, 0, 0}, 1,
			'{1, 0, -16'sd16384, 0, 32'h1_0000}},
		'{'{KindSphSph, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000, ONE, 7, 9, ONE, 3, 3}, 0,
			'{0, 0, 0, 0, 0}},
		'{'{KindSphSph, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			EMAX, EMAX, EMAX, EMAX, 0, 0}, 0, '{0, 0, 0, 0, 0}},
		'{'{KindSphSph, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			EMAX, 0, 0, EMAX, 0, 0}, 0, '{0, 0, 0, 0, 0}},
		'{'{KindSphBox, 0, 0, 0, ONE, 0, 0, ONE, ONE, ONE}, 1,
			'{1, 16'sd16384, 0, 0, 32'h1_0000}},
		'{'{KindSphBox, 32'sh1_8000, 0, 0, ONE, 0, 0, ONE, ONE, ONE}, 1,
			'{1, 16'sd16384, 0, 0, 32'h8000}},
		'{'{KindSphBox, 32'sh1_0000, 32'sh1_4000, -32'sh1_6000, ONE, 0, 0, ONE, ONE, ONE}, 0,
			'{0, 0, 0, 0, 0}},
		'{'{KindBoxSph, 32'sh1_8000, 0, 0, ONE, ONE, ONE, ONE, 0, 0}, 1,
			'{1, 16'sd16384, 0, 0, 32'h8000}},
		'{'{KindBoxSph, 0, 0, 0, ONE, ONE, ONE, ONE, 0, 0}, 1,
			'{1, 16'sd16384, 0, 0, 32'h1_0000}},
		'{'{KindBoxSph, -32'sh1_2000, 32'sh1_3000, 32'sh1_1000, ONE, ONE, ONE, ONE, 0, 0}, 0,
			'{0, 0, 0, 0, 0}},
		'{'{KindBoxSph, 32'sh2_0000, 0, 0, ONE, ONE, ONE, ONE, 0, 0}, 1,
			'{0, 0, 0, 0, 0}},
		'{'{KindSphBox, 32'h8000_0000, 32'h7FFF_FFFF, 0, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX}, 0,
			'{0, 0, 0, 0, 0}}
	};

	// mostly small, overlapping pairs so that contacts are common
	function automatic pair_t random_pair();
		pair_t p;
		int scale;
		p.kind = 2'($urandom_range(0, 3));
		if ($urandom_range(0, 9) == 0) begin
			p.ox = $urandom; p.oy = $urandom; p.oz = $urandom;
			p.ax = 31'($urandom); p.ay = 31'($urandom); p.az = 31'($urandom);
			p.bx = 31'($urandom); p.by = 31'($urandom); p.bz = 31'($urandom);
		end else begin
			scale = $urandom_range(8, 20);
			p.ax = 31'($urandom_range(0, 1 << scale));
			p.ay = 31'($urandom_range(0, 1 << scale));
			p.az = 31'($urandom_range(0, 1 << scale));
			p.bx = 31'($urandom_range(0, 1 << scale));
			p.by = 31'($urandom_range(0, 1 << scale));
			p.bz = 31'($urandom_range(0, 1 << scale));
			p.ox = $signed($urandom_range(0, 3 << scale)) - (3 << (scale - 1));
			p.oy = $signed($urandom_range(0, 3 << scale)) - (3 << (scale - 1));
			p.oz = $signed($urandom_range(0, 3 << scale)) - (3 << (scale - 1));
		end
		return p;
	endfunction

	function automatic void queue_contact(contact_t c);
		expected_contacts.insert(expected_contacts.size(), c);
	endfunction

	task automatic send_pair(pair_t p, bit known, contact_t c);
		while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		pair_kind <= p.kind;
		offset_x <= p.ox; offset_y <= p.oy; offset_z <= p.oz;
		a_ext_x <= p.ax; a_ext_y <= p.ay; a_ext_z <= p.az;
		b_ext_x <= p.bx; b_ext_y <= p.by; b_ext_z <= p.bz;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		queue_contact(known ? c : predict_contact(p));
	endtask

	always @(posedge clk) begin
		contact_t e;
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("collider_pair_contact_test regression: fail");
			$finish;
		end
		if (arst_n) begin
			out_stall <= recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct;
			if (out_valid && !out_stall) begin
				if (expected_contacts.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected contact result: exp none got %b %0d %0d %0d %h",
							collided, normal_x, normal_y, normal_z, penetration);
				end else begin
					e = expected_contacts.pop_front();
					if (collided !== e.hit || normal_x !== e.nx || normal_y !== e.ny ||
							normal_z !== e.nz || penetration !== e.pen) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp %b %0d %0d %0d %h got %b %0d %0d %0d %h",
								e.hit, e.nx, e.ny, e.nz, e.pen,
								collided, normal_x, normal_y, normal_z, penetration);
					end
				end
			end
		end
	end

	initial begin
		contact_t none;
		none = '{0, 0, 0, 0, 0};
		arst_n = 0;
		in_valid = 0;
		out_stall = 0;
		pair_kind = 0;
		{offset_x, offset_y, offset_z} = '0;
		{a_ext_x, a_ext_y, a_ext_z, b_ext_x, b_ext_y, b_ext_z} = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (rows[i]) send_pair(rows[i].p, rows[i].known, rows[i].c);
		in_valid <= 0;
		// hold off until the pipeline has drained
		while (expected_contacts.size() != 0) @(posedge clk);
		send_idle_pct = 22;
		recv_idle_pct = 71;
		repeat (180) send_pair(random_pair(), 0, none);
		send_idle_pct = 71;
		recv_idle_pct = 22;
		repeat (180) send_pair(random_pair(), 0, none);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (190) send_pair(random_pair(), 0, none);
		in_valid <= 0;
		while (expected_contacts.size() != 0) @(posedge clk);
		repeat (NFB + 60) @(posedge clk);
		if (mismatches == 0 && expected_contacts.size() == 0)
			$display("collider_pair_contact_test regression: pass");
		else
			$display("collider_pair_contact_test regression: fail");
		$finish;
	end

endmodule
